// ===== hw/rtl/plle_pkg.sv =====
// plle_pkg: shared constants for the pooled linked list engine
// no dependencies; used by plle_in_if and the top module
`default_nettype none

package plle_pkg;

  // default pool depth and value width
  localparam int unsigned POOL_SIZE_DEF   = 64;
  localparam int unsigned VALUE_WIDTH_DEF = 16;

  // command codes
  localparam logic CMD_INSERT = 1'b0;
  localparam logic CMD_REMOVE = 1'b1;

endpackage

`default_nettype wire

// ===== hw/rtl/plle_in_if.sv =====
// plle_in_if: command channel (valid/ready, command and value)
// depends on plle_pkg for the default value width
`default_nettype none

interface plle_in_if #(
  parameter int unsigned VALUE_WIDTH = plle_pkg::VALUE_WIDTH_DEF
) ();
  logic                   valid;
  logic                   ready;
  logic                   command;
  logic [VALUE_WIDTH-1:0] value;

  modport source (output valid, command, value, input ready);
  modport sink   (input valid, command, value, output ready);
endinterface

`default_nettype wire

// ===== hw/rtl/plle_out_if.sv =====
// plle_out_if: result channel (valid/ready, ok flag)
// no dependencies
`default_nettype none

interface plle_out_if ();
  logic valid;
  logic ready;
  logic ok;

  modport source (output valid, ok, input ready);
  modport sink   (input valid, ok, output ready);
endinterface

`default_nettype wire

// ===== hw/rtl/plle_ram.sv =====
// plle_ram: generic simple dual-port ram, one write and one registered read port
// no dependencies
`default_nettype none

module plle_ram #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = 64
) (
  input  wire logic                     clk_i,
  input  wire logic                     we_i,
  input  wire logic [$clog2(DEPTH)-1:0] waddr_i,
  input  wire logic [WIDTH-1:0]         wdata_i,
  input  wire logic [$clog2(DEPTH)-1:0] raddr_i,
  output      logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
    rdata_o <= mem[raddr_i];
  end

endmodule

`default_nettype wire

// ===== hw/rtl/pooled_linked_list_engine_top.sv =====
// Pooled linked list engine: a singly linked list of values kept in a fixed pool of
// POOL_SIZE nodes. Node values and links sit in two synchronous rams; freed nodes go
// on a free stack in a third ram, and never-used nodes are handed out by a fill
// counter, so no clearing pass follows reset. An insert answers ok=0 when the pool is
// full; in unsorted mode it links at the tail, in sorted mode after the last node
// whose value is strictly smaller. A remove unlinks the first node equal to the value.
// One transaction is processed at a time. The list walk visits one node per cycle,
// the link read from the ram feeding straight into the next read address, and visits
// at most POOL_SIZE nodes. A remove passes through walk (if the list is not empty) to
// done; an insert passes through start, walk (sorted mode on a non-empty list only),
// link and fix (skipped when it lands at the head) to done; an insert into a full pool
// goes straight to done. The next transaction is taken while a result still waits on
// the output register. Depends on plle_pkg, plle_in_if, plle_out_if and plle_ram.
`default_nettype none

module pooled_linked_list_engine_top #(
  parameter int unsigned POOL_SIZE   = plle_pkg::POOL_SIZE_DEF,
  parameter int unsigned VALUE_WIDTH = plle_pkg::VALUE_WIDTH_DEF
) (
  input  wire logic  clk_i,
  input  wire logic  rst_ni,
  input  wire logic  sorted_mode_we_i,
  input  wire logic  sorted_mode_wdata_i,
  plle_in_if.sink    in_i,
  plle_out_if.source out_o
);

  localparam int unsigned IdxW = $clog2(POOL_SIZE);
  localparam int unsigned PtrW = $clog2(POOL_SIZE + 1);
  localparam logic [PtrW-1:0] NullPtr = PtrW'(POOL_SIZE);

  typedef enum logic [5:0] {
    ST_IDLE  = 6'b000001,
    ST_START = 6'b000010,
    ST_WALK  = 6'b000100,
    ST_LINK  = 6'b001000,
    ST_FIX   = 6'b010000,
    ST_DONE  = 6'b100000
  } state_e;

  state_e                 state_q, state_d;
  logic                   sorted_q;
  logic                   cmd_q, cmd_d;
  logic [VALUE_WIDTH-1:0] val_q, val_d;
  logic [PtrW-1:0]        head_q, head_d;
  logic [PtrW-1:0]        tail_q, tail_d;
  logic [PtrW-1:0]        prev_q, prev_d;
  logic [PtrW-1:0]        cur_q, cur_d;
  logic [IdxW-1:0]        slot_q, slot_d;
  logic [PtrW-1:0]        fresh_q, fresh_d;
  logic [PtrW-1:0]        sp_q, sp_d;
  logic                   ok_pend_q, ok_pend_d;
  logic                   out_valid_q, out_valid_d;
  logic                   ok_q, ok_d;

  // node rams
  logic [IdxW-1:0]        node_raddr;
  logic [VALUE_WIDTH-1:0] rd_val;
  logic [PtrW-1:0]        rd_link;
  logic                   val_we;
  logic [IdxW-1:0]        val_waddr;
  logic                   link_we;
  logic [IdxW-1:0]        link_waddr;
  logic [PtrW-1:0]        link_wdata;

  // free stack ram
  logic                   fs_we;
  logic [IdxW-1:0]        fs_waddr;
  logic [IdxW-1:0]        fs_wdata;
  logic [IdxW-1:0]        fs_raddr;
  logic [IdxW-1:0]        fs_rdata;

  logic                   in_fire;
  logic                   pool_full;
  logic                   walk_more;
  logic [PtrW-1:0]        sp_dec;

  assign in_i.ready  = (state_q == ST_IDLE);
  assign in_fire     = in_i.valid && in_i.ready;
  assign out_o.valid = out_valid_q;
  assign out_o.ok    = ok_q;

  assign pool_full = (sp_q == '0) && (fresh_q == NullPtr);
  assign sp_dec    = sp_q - PtrW'(1);
  assign fs_raddr  = sp_dec[IdxW-1:0];

  // insert walks past smaller values, remove walks past unequal ones
  assign walk_more = (cmd_q == plle_pkg::CMD_INSERT) ? (rd_val < val_q) : (rd_val != val_q);

  always_comb begin
    state_d     = state_q;
    cmd_d       = cmd_q;
    val_d       = val_q;
    head_d      = head_q;
    tail_d      = tail_q;
    prev_d      = prev_q;
    cur_d       = cur_q;
    slot_d      = slot_q;
    fresh_d     = fresh_q;
    sp_d        = sp_q;
    ok_pend_d   = ok_pend_q;
    out_valid_d = out_valid_q;
    ok_d        = ok_q;

    node_raddr  = cur_q[IdxW-1:0];
    val_we      = 1'b0;
    val_waddr   = slot_q;
    link_we     = 1'b0;
    link_waddr  = slot_q;
    link_wdata  = cur_q;
    fs_we       = 1'b0;
    fs_waddr    = sp_q[IdxW-1:0];
    fs_wdata    = cur_q[IdxW-1:0];

    if (out_valid_q && out_o.ready) begin
      out_valid_d = 1'b0;
    end

    unique case (state_q)
      ST_IDLE: begin
        node_raddr = head_q[IdxW-1:0];
        if (in_fire) begin
          cmd_d = in_i.command;
          val_d = in_i.value;
          if (in_i.command == plle_pkg::CMD_INSERT) begin
            if (pool_full) begin
              ok_pend_d = 1'b0;
              state_d   = ST_DONE;
            end else begin
              state_d = ST_START;
            end
          end else if (head_q == NullPtr) begin
            ok_pend_d = 1'b0;
            state_d   = ST_DONE;
          end else begin
            cur_d   = head_q;
            prev_d  = NullPtr;
            state_d = ST_WALK;
          end
        end
      end

      ST_START: begin
        // take a recycled node first, else the next never-used one
        if (sp_q != '0) begin
          slot_d = fs_rdata;
          sp_d   = sp_dec;
        end else begin
          slot_d  = fresh_q[IdxW-1:0];
          fresh_d = fresh_q + PtrW'(1);
        end
        node_raddr = head_q[IdxW-1:0];
        if (sorted_q && (head_q != NullPtr)) begin
          cur_d   = head_q;
          prev_d  = NullPtr;
          state_d = ST_WALK;
        end else begin
          cur_d   = NullPtr;
          prev_d  = sorted_q ? NullPtr : tail_q;
          state_d = ST_LINK;
        end
      end

      ST_WALK: begin
        if (walk_more) begin
          node_raddr = rd_link[IdxW-1:0];
          prev_d     = cur_q;
          cur_d      = rd_link;
          if (rd_link == NullPtr) begin
            if (cmd_q == plle_pkg::CMD_INSERT) begin
              state_d = ST_LINK;
            end else begin
              ok_pend_d = 1'b0;
              state_d   = ST_DONE;
            end
          end
        end else if (cmd_q == plle_pkg::CMD_INSERT) begin
          state_d = ST_LINK;
        end else begin
          // unlink cur and push it on the free stack
          if (prev_q == NullPtr) begin
            head_d = rd_link;
          end else begin
            link_we    = 1'b1;
            link_waddr = prev_q[IdxW-1:0];
            link_wdata = rd_link;
          end
          if (cur_q == tail_q) begin
            tail_d = prev_q;
          end
          fs_we     = 1'b1;
          sp_d      = sp_q + PtrW'(1);
          ok_pend_d = 1'b1;
          state_d   = ST_DONE;
        end
      end

      ST_LINK: begin
        val_we     = 1'b1;
        link_we    = 1'b1;
        link_waddr = slot_q;
        link_wdata = cur_q;
        if (prev_q == NullPtr) begin
          head_d = PtrW'(slot_q);
        end
        // also covers the empty list, where prev and tail are both null
        if (prev_q == tail_q) begin
          tail_d = PtrW'(slot_q);
        end
        ok_pend_d = 1'b1;
        state_d   = (prev_q == NullPtr) ? ST_DONE : ST_FIX;
      end

      ST_FIX: begin
        link_we    = 1'b1;
        link_waddr = prev_q[IdxW-1:0];
        link_wdata = PtrW'(slot_q);
        state_d    = ST_DONE;
      end

      ST_DONE: begin
        if (!out_valid_q || out_o.ready) begin
          out_valid_d = 1'b1;
          ok_d        = ok_pend_q;
          state_d     = ST_IDLE;
        end
      end

      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      sorted_q    <= 1'b0;
      head_q      <= NullPtr;
      tail_q      <= NullPtr;
      fresh_q     <= '0;
      sp_q        <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      head_q      <= head_d;
      tail_q      <= tail_d;
      fresh_q     <= fresh_d;
      sp_q        <= sp_d;
      out_valid_q <= out_valid_d;
      if (sorted_mode_we_i) begin
        sorted_q <= sorted_mode_wdata_i;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    cmd_q     <= cmd_d;
    val_q     <= val_d;
    prev_q    <= prev_d;
    cur_q     <= cur_d;
    slot_q    <= slot_d;
    ok_pend_q <= ok_pend_d;
    ok_q      <= ok_d;
  end

  plle_ram #(
    .WIDTH (VALUE_WIDTH),
    .DEPTH (POOL_SIZE)
  ) u_value_ram (
    .clk_i   (clk_i),
    .we_i    (val_we),
    .waddr_i (val_waddr),
    .wdata_i (val_q),
    .raddr_i (node_raddr),
    .rdata_o (rd_val)
  );

  plle_ram #(
    .WIDTH (PtrW),
    .DEPTH (POOL_SIZE)
  ) u_link_ram (
    .clk_i   (clk_i),
    .we_i    (link_we),
    .waddr_i (link_waddr),
    .wdata_i (link_wdata),
    .raddr_i (node_raddr),
    .rdata_o (rd_link)
  );

  plle_ram #(
    .WIDTH (IdxW),
    .DEPTH (POOL_SIZE)
  ) u_free_ram (
    .clk_i   (clk_i),
    .we_i    (fs_we),
    .waddr_i (fs_waddr),
    .wdata_i (fs_wdata),
    .raddr_i (fs_raddr),
    .rdata_o (fs_rdata)
  );

endmodule

`default_nettype wire
